FILE: design/lius_pkg.sv
// ----------------------------------------------------------------------------
// lius_pkg
// Shared types, codes and constants for the linear interpolation upsampler.
// ----------------------------------------------------------------------------
package lius_pkg;

  localparam int SAMPLE_BITS  = 24;
  localparam int MAX_CHANNELS = 8;
  localparam int MAX_FACTOR   = 8;
  localparam int SCALE_FULL   = 2000;

  localparam int CH_W  = 3;
  localparam int CFG_W = 4;

  localparam logic [1:0] KIND_CLEAR    = 2'd0;
  localparam logic [1:0] KIND_MEASURE  = 2'd1;
  localparam logic [1:0] KIND_RESAMPLE = 2'd2;
  localparam logic [1:0] KIND_UNUSED   = 2'd3;

  localparam logic [1:0] REG_FACTOR   = 2'd0;
  localparam logic [1:0] REG_CHANNELS = 2'd1;
  localparam logic [1:0] REG_INTEGER  = 2'd2;

  typedef struct packed {
    logic [1:0]                    kind;
    logic signed [SAMPLE_BITS-1:0] sample;
  } lius_in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] value;
    logic [2:0]                    channel;
    logic [2:0]                    phase;
    logic                          last;
  } lius_out_t;

endpackage

FILE: design/lius_ram.sv
// ----------------------------------------------------------------------------
// lius_ram
// Single write port, single read port memory with registered read data.
// ----------------------------------------------------------------------------
module lius_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 8,
  parameter int AW    = 3
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: design/lius_div.sv
// ----------------------------------------------------------------------------
// lius_div
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lius_div #(
  parameter int NW = 42,
  parameter int DW = 29
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo,
  output logic [DW-1:0] rem
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] quo_r;
  logic [DW-1:0] rem_r, den_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r, done_r;
  logic [DW:0]   trial;
  logic          fits;

  assign trial = {rem_r, quo_r[NW-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= fits ? DW'(trial - {1'b0, den_r}) : trial[DW-1:0];
      quo_r <= {quo_r[NW-2:0], fits};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

FILE: design/linear_interp_upsampler.sv
// ----------------------------------------------------------------------------
// linear_interp_upsampler
// Multi-channel linear interpolation upsampler with optional peak scaling.
// ----------------------------------------------------------------------------
// Input beats carry a kind and one sample for the next channel in row order.
// Clear, unused and resample beats that do not end a row complete in S_IDLE;
// measure beats also pass through S_MEAS (read-modify-write of the peak memory).
// The beat that ends a row starts a burst of factor*channels result beats,
// phase-major, the final one flagged last. Each result passes through S_RD,
// S_NUM, S_PREP, S_LOAD, the 42-step bit-serial divider and S_OUT;
// after the burst the row is copied to the previous-row memory, one
// channel at a time through S_CPRD and S_CPWR. No input is taken meanwhile.
// Results sit in an output register, so a stalled receiver only holds the
// next result back once it is computed.
// Configuration is a plain write port: factor, channels, integer mode.
// Reset (synchronous, active low) empties the pipeline, clears the column
// index and marks previous-row, current-row and peak entries as zero through
// valid bits; a clear beat clears the same index and valid bits and keeps the
// configuration.
// ----------------------------------------------------------------------------
module linear_interp_upsampler
  import lius_pkg::*;
#(
  parameter int CHANNELS_MAX = MAX_CHANNELS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  lius_in_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output lius_out_t        out_data,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_idx,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam int SB    = SAMPLE_BITS;
  localparam int NUM_W = SB + 6;
  localparam int DEN_W = SB + 4;
  localparam int N_W   = NUM_W + 14;
  localparam int NM_W  = N_W - 2;
  localparam int DV_W  = DEN_W + 1;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MEAS = 4'd1;
  localparam logic [3:0] S_RD   = 4'd2;
  localparam logic [3:0] S_NUM  = 4'd3;
  localparam logic [3:0] S_PREP = 4'd4;
  localparam logic [3:0] S_DIV  = 4'd5;
  localparam logic [3:0] S_OUT  = 4'd6;
  localparam logic [3:0] S_CPRD = 4'd7;
  localparam logic [3:0] S_CPWR = 4'd8;
  localparam logic [3:0] S_LOAD = 4'd9;

  logic [3:0]       state_r, state_nxt;
  logic [CFG_W-1:0] factor_r, channels_r;
  logic             int_r;
  logic [CH_W-1:0]  col_r, col_nxt, ch_r, ch_nxt, meas_col_r;
  logic [2:0]       ph_r, ph_nxt;
  logic [CHANNELS_MAX-1:0] prev_vld_r, prev_vld_nxt, peak_vld_r, peak_vld_nxt;
  logic [CHANNELS_MAX-1:0] cur_vld_r, cur_vld_nxt;
  logic [SB-1:0]    mag_r;

  logic signed [NUM_W-1:0] num_r;
  logic [DEN_W-1:0]        den_r;
  logic                    neg_r, zero_r;
  logic [NM_W-1:0]         nmag_r;
  logic [DV_W-1:0]         dval_r;

  logic             out_valid_r;
  lius_out_t        out_data_r;

  logic [3:0]       nf, nch;
  logic [CH_W-1:0]  col_eff;
  logic [3:0]       col_inc;
  logic             accept, load_out;

  logic [SB-1:0]    prev_q, cur_q, peak_q;
  logic             peak_we, cur_we, prev_we;
  logic [SB-1:0]    peak_wd;
  logic [CH_W-1:0]  peak_ra;

  logic             div_start, div_done;
  logic [NM_W-1:0]  div_quo;
  logic [DV_W-1:0]  div_rem;

  // effective register values
  always_comb begin
    nf = factor_r;
    if (factor_r < 4'd2) nf = 4'd2;
    if (factor_r > 4'(MAX_FACTOR)) nf = 4'(MAX_FACTOR);
    nch = channels_r;
    if (channels_r < 4'd1) nch = 4'd1;
    if (channels_r > 4'(CHANNELS_MAX)) nch = 4'(CHANNELS_MAX);
  end

  assign col_eff  = ({1'b0, col_r} >= nch) ? '0 : col_r;
  assign col_inc  = {1'b0, col_eff} + 4'd1;
  assign in_ready = state_r == S_IDLE;
  assign accept   = in_valid && in_ready;
  assign load_out = state_r == S_OUT && (!out_valid_r || out_ready);

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      factor_r   <= 4'd2;
      channels_r <= 4'd1;
      int_r      <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_FACTOR:   factor_r   <= cfg_wdata;
        REG_CHANNELS: channels_r <= cfg_wdata;
        REG_INTEGER:  int_r      <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // memories
  assign peak_ra = (state_r == S_IDLE) ? col_eff : ch_r;
  assign cur_we  = accept && in_data.kind == KIND_RESAMPLE;
  assign prev_we = state_r == S_CPWR;
  assign peak_we = state_r == S_MEAS;

  always_comb begin
    logic [SB-1:0] old_pk;
    old_pk  = peak_vld_r[meas_col_r] ? peak_q : '0;
    peak_wd = (mag_r > old_pk) ? mag_r : old_pk;
  end

  lius_ram #(.WIDTH(SB), .DEPTH(CHANNELS_MAX), .AW(CH_W)) u_prev_ram (
    .clk(clk), .we(prev_we), .wr_addr(ch_r), .wr_data(cur_q),
    .rd_addr(ch_r), .rd_data(prev_q)
  );

  lius_ram #(.WIDTH(SB), .DEPTH(CHANNELS_MAX), .AW(CH_W)) u_cur_ram (
    .clk(clk), .we(cur_we), .wr_addr(col_eff), .wr_data(in_data.sample),
    .rd_addr(ch_r), .rd_data(cur_q)
  );

  lius_ram #(.WIDTH(SB), .DEPTH(CHANNELS_MAX), .AW(CH_W)) u_peak_ram (
    .clk(clk), .we(peak_we), .wr_addr(meas_col_r), .wr_data(peak_wd),
    .rd_addr(peak_ra), .rd_data(peak_q)
  );

  // control
  always_comb begin
    state_nxt    = state_r;
    col_nxt      = col_r;
    ch_nxt       = ch_r;
    ph_nxt       = ph_r;
    prev_vld_nxt = prev_vld_r;
    peak_vld_nxt = peak_vld_r;
    cur_vld_nxt  = cur_vld_r;
    div_start    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_data.kind)
            KIND_CLEAR: begin
              col_nxt      = '0;
              prev_vld_nxt = '0;
              peak_vld_nxt = '0;
              cur_vld_nxt  = '0;
            end
            KIND_MEASURE: begin
              col_nxt   = (col_inc >= nch) ? '0 : col_inc[CH_W-1:0];
              state_nxt = S_MEAS;
            end
            KIND_RESAMPLE: begin
              cur_vld_nxt[col_eff] = 1'b1;
              if (col_inc < nch) begin
                col_nxt = col_inc[CH_W-1:0];
              end else begin
                col_nxt   = '0;
                ch_nxt    = '0;
                ph_nxt    = '0;
                state_nxt = S_RD;
              end
            end
            KIND_UNUSED: ;
            default: ;
          endcase
        end
      end
      S_MEAS: begin
        peak_vld_nxt[meas_col_r] = 1'b1;
        state_nxt = S_IDLE;
      end
      S_RD:   state_nxt = S_NUM;
      S_NUM:  state_nxt = S_PREP;
      S_PREP: state_nxt = S_LOAD;
      // dividend and divisor registers are settled here
      S_LOAD: begin
        div_start = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_done) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (load_out) begin
          if ({1'b0, ch_r} + 4'd1 >= nch) begin
            ch_nxt = '0;
            if ({1'b0, ph_r} + 4'd1 >= nf) begin
              ph_nxt    = '0;
              state_nxt = S_CPRD;
            end else begin
              ph_nxt    = ph_r + 3'd1;
              state_nxt = S_RD;
            end
          end else begin
            ch_nxt    = ch_r + 1'b1;
            state_nxt = S_RD;
          end
        end
      end
      S_CPRD: state_nxt = S_CPWR;
      S_CPWR: begin
        // an entry zeroed by a clear carries over as zero
        prev_vld_nxt[ch_r] = cur_vld_r[ch_r];
        if ({1'b0, ch_r} + 4'd1 >= nch) begin
          ch_nxt    = '0;
          state_nxt = S_IDLE;
        end else begin
          ch_nxt    = ch_r + 1'b1;
          state_nxt = S_CPRD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      col_r      <= '0;
      ch_r       <= '0;
      ph_r       <= '0;
      prev_vld_r <= '0;
      peak_vld_r <= '0;
      cur_vld_r  <= '0;
    end else begin
      state_r    <= state_nxt;
      col_r      <= col_nxt;
      ch_r       <= ch_nxt;
      ph_r       <= ph_nxt;
      prev_vld_r <= prev_vld_nxt;
      peak_vld_r <= peak_vld_nxt;
      cur_vld_r  <= cur_vld_nxt;
    end
  end

  // measure capture
  always_ff @(posedge clk) begin
    if (accept) begin
      meas_col_r <= col_eff;
      mag_r      <= in_data.sample[SB-1] ? SB'(-in_data.sample) : in_data.sample;
    end
  end

  // numerator prev*nf + (cur-prev)*phase and denominator nf*peak
  always_ff @(posedge clk) begin
    if (state_r == S_NUM) begin
      logic signed [NUM_W-1:0] prev_x, cur_x, diff_x;
      logic [SB-1:0]           pk;
      prev_x = prev_vld_r[ch_r] ? NUM_W'($signed(prev_q)) : '0;
      cur_x  = cur_vld_r[ch_r] ? NUM_W'($signed(cur_q)) : '0;
      diff_x = cur_x - prev_x;
      pk     = peak_vld_r[ch_r] ? peak_q : '0;
      num_r  <= prev_x * $signed(NUM_W'(nf)) + diff_x * $signed(NUM_W'(ph_r));
      den_r  <= DEN_W'(nf) * DEN_W'(pk);
    end
  end

  // dividend and divisor with rounding offset folded in
  always_ff @(posedge clk) begin
    if (state_r == S_PREP) begin
      logic signed [N_W-1:0] n_full;
      if (int_r) begin
        n_full = N_W'(num_r) * $signed(N_W'(2 * SCALE_FULL))
               + $signed(N_W'({1'b0, den_r}));
        dval_r <= {den_r, 1'b0};
      end else begin
        n_full = (N_W'(num_r) <<< 1) + $signed(N_W'(nf));
        dval_r <= DV_W'({nf, 1'b0});
      end
      neg_r  <= n_full[N_W-1];
      nmag_r <= n_full[N_W-1] ? NM_W'(-n_full) : n_full[NM_W-1:0];
      zero_r <= int_r && den_r == '0;
    end
  end

  lius_div #(.NW(NM_W), .DW(DV_W)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .num(nmag_r), .den(dval_r),
    .done(div_done), .quo(div_quo), .rem(div_rem)
  );

  // floor for negative dividends, then saturate
  logic signed [N_W-1:0] q_s;
  logic signed [SB-1:0]  val;
  always_comb begin
    q_s = $signed(N_W'(div_quo));
    if (neg_r) q_s = -(q_s + $signed(N_W'(|div_rem)));
    if (zero_r) val = '0;
    else if (q_s > $signed(N_W'({1'b0, {(SB-1){1'b1}}}))) val = {1'b0, {(SB-1){1'b1}}};
    else if (q_s < -$signed(N_W'({1'b1, {(SB-1){1'b0}}}))) val = {1'b1, {(SB-1){1'b0}}};
    else val = q_s[SB-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r.value   <= val;
      out_data_r.channel <= ch_r;
      out_data_r.phase   <= ph_r;
      out_data_r.last    <= ({1'b0, ch_r} + 4'd1 >= nch) && ({1'b0, ph_r} + 4'd1 >= nf);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
